/* rtl/odc2p_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and dither tables for the chunky-to-planar dither unit.
package odc2p_pkg;

	localparam int BLOCK_PIXELS = 16;
	localparam int POS_W        = 4;
	localparam int PEN_W        = 4;
	localparam int MIX_W        = 5;
	localparam int THR_W        = 4;
	localparam int MODE_W       = 3;
	localparam int PLANES       = 4;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_PIXELS - 1);

	// Request opcodes
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	// Dither mode codes; unused codes fall back to Bayer 4x4
	localparam logic [MODE_W-1:0] MODE_NEAREST  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_BAYER2   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BAYER4   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_HALFTONE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_NOISE    = 3'd4;

	typedef logic [PEN_W-1:0] pen_t;

	typedef struct packed {
		logic [MIX_W-1:0] mix;
		pen_t             far_pen;
		pen_t             near_pen;
	} entry_t;

	// Pixel request handed from the front end to the packer
	typedef struct packed {
		entry_t           entry;
		logic [1:0]       row_phase;
		logic [THR_W-1:0] noise_level;
	} pix_req_t;

	localparam logic [THR_W-1:0] BAYER4_TAB [16] = '{
		4'd0, 4'd8, 4'd2, 4'd10, 4'd12, 4'd4, 4'd14, 4'd6,
		4'd3, 4'd11, 4'd1, 4'd9, 4'd15, 4'd7, 4'd13, 4'd5
	};
	localparam logic [THR_W-1:0] BAYER2_TAB [4] = '{4'd2, 4'd10, 4'd14, 4'd6};
	localparam logic [THR_W-1:0] HALFTONE_TAB [16] = '{
		4'd6, 4'd7, 4'd8, 4'd9, 4'd5, 4'd0, 4'd1, 4'd10,
		4'd4, 4'd3, 4'd2, 4'd11, 4'd15, 4'd14, 4'd13, 4'd12
	};

	// Pen choice for one pixel; the column is the low two bits of the position
	function automatic pen_t pick_pen(input logic [MODE_W-1:0] mode,
		input pix_req_t req, input logic [POS_W-1:0] pos);
		logic [3:0]       cell_sel;
		logic [THR_W-1:0] thr;
		pen_t             pen;
		cell_sel = {req.row_phase, pos[1:0]};
		case (mode)
			MODE_BAYER2:   thr = BAYER2_TAB[{cell_sel[2], cell_sel[0]}];
			MODE_HALFTONE: thr = HALFTONE_TAB[cell_sel];
			MODE_NOISE:    thr = req.noise_level;
			default:       thr = BAYER4_TAB[cell_sel];
		endcase
		if (mode == MODE_NEAREST) begin
			pen = req.entry.near_pen;
		end else if (req.entry.mix > {1'b0, thr}) begin
			pen = req.entry.far_pen;
		end else begin
			pen = req.entry.near_pen;
		end
		return pen;
	endfunction

endpackage

/* rtl/odc2p_front.sv */
`timescale 1ns / 1ps
// Front end: request intake, pair table memory and table lookup stage.
module odc2p_front import odc2p_pkg::*; #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         op,
	input  logic [7:0]   pixel_index,
	input  logic [3:0]   near_pen,
	input  logic [3:0]   far_pen,
	input  logic [4:0]   mix_level,
	input  logic [1:0]   row_phase,
	input  logic [3:0]   noise_level,
	output logic         req_valid,
	input  logic         req_ready,
	output pix_req_t     req
);

	localparam int AW = $clog2(PALETTE_ENTRIES);

	entry_t           mem [PALETTE_ENTRIES];
	entry_t           rdata_s1;
	logic             hit_s1;
	logic [1:0]       row_s1;
	logic [THR_W-1:0] noise_s1;
	logic             valid_s1;
	logic             accept;
	logic             in_range;
	logic [AW-1:0]    addr;

	assign in_range = {1'b0, pixel_index} < 9'(PALETTE_ENTRIES);
	assign addr     = pixel_index[AW-1:0];
	assign in_ready = !valid_s1 || req_ready;
	assign accept   = in_valid && in_ready;

	// Table write and registered lookup
	always_ff @(posedge clk) begin
		if (accept && op == OP_WRITE && in_range) begin
			mem[addr] <= '{mix: mix_level, far_pen: far_pen, near_pen: near_pen};
		end
		if (accept && op == OP_PIXEL) begin
			rdata_s1 <= mem[addr];
			hit_s1   <= in_range;
			row_s1   <= row_phase;
			noise_s1 <= noise_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && op == OP_PIXEL;
		end
	end

	// Out-of-range index reads as an all-zero entry
	assign req_valid       = valid_s1;
	assign req.entry       = hit_s1 ? rdata_s1 : '0;
	assign req.row_phase   = row_s1;
	assign req.noise_level = noise_s1;

	a_stall_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("front stalled with empty lookup stage");

endmodule

/* rtl/odc2p_fifo.sv */
`timescale 1ns / 1ps
// Two-entry queue of pixel requests between front end and packer.
module odc2p_fifo import odc2p_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  pix_req_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output pix_req_t pop_data
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	pix_req_t        slots_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count overflow");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CW'(DEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");

endmodule

/* rtl/odc2p_back.sv */
`timescale 1ns / 1ps
// Back end: pen selection, plane shifting and block output register.
module odc2p_back import odc2p_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [MODE_W-1:0] mode,
	input  logic              req_valid,
	output logic              req_ready,
	input  pix_req_t          req,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       plane_word_0,
	output logic [15:0]       plane_word_1,
	output logic [15:0]       plane_word_2,
	output logic [15:0]       plane_word_3
);

	logic [BLOCK_PIXELS-1:0] acc_q   [PLANES];
	logic [BLOCK_PIXELS-1:0] acc_nx  [PLANES];
	logic [BLOCK_PIXELS-1:0] word_q  [PLANES];
	logic [POS_W-1:0]        pos_q;
	logic                    out_valid_q;
	logic                    pop;
	logic                    last;
	logic [BLOCK_PIXELS-1:0] slot;
	pen_t                    pen;

	assign last      = pos_q == LAST_POS;
	// Only the closing pixel of a block needs room in the output register
	assign req_ready = !last || !out_valid_q || out_ready;
	assign pop       = req_valid && req_ready;
	assign pen       = pick_pen(mode, req, pos_q);
	assign slot      = {1'b1, {(BLOCK_PIXELS-1){1'b0}}} >> pos_q;

	always_comb begin
		for (int k = 0; k < PLANES; k++) begin
			acc_nx[k] = acc_q[k] | (pen[k] ? slot : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && last) begin
			for (int k = 0; k < PLANES; k++) begin
				word_q[k] <= acc_nx[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < PLANES; k++) begin
				acc_q[k] <= '0;
			end
		end else begin
			if (pop) begin
				pos_q <= last ? '0 : pos_q + 1'b1;
				for (int k = 0; k < PLANES; k++) begin
					acc_q[k] <= last ? '0 : acc_nx[k];
				end
			end
			if (pop && last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign plane_word_0 = word_q[0];
	assign plane_word_1 = word_q[1];
	assign plane_word_2 = word_q[2];
	assign plane_word_3 = word_q[3];

	a_block_emits: assert property (@(posedge clk) disable iff (!arst_n)
		pop && last |=> out_valid_q && pos_q == '0)
		else $error("block close did not raise output");

	a_block_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && last |=> acc_q[0] == '0 && acc_q[1] == '0 && acc_q[2] == '0
			&& acc_q[3] == '0)
		else $error("accumulators not cleared after block");

endmodule

/* rtl/ordered_dither_chunky_to_planar_unit.sv */
`timescale 1ns / 1ps
// Top level of the ordered-dither chunky-to-planar converter.
//
// Takes one request per cycle, sustained while out_ready stays high:
// either a pair table write (op 0) or a pixel (op 1). A pixel's palette
// index looks up its nearest pen, second pen and mix level in a 256-entry
// table RAM with a registered read; the second pen wins when the mix level
// is above the dither threshold picked by dither_mode (not in nearest
// mode). Pens are shifted into four plane words, pixel 0 in bit 15, and
// after every 16th pixel the four words are presented together. A pixel
// is packed after the registered table read and the two-entry queue; a
// 16th pixel's block result is presented from the edge that packs it. The
// front end (lookup) and back end (packer plus output register) stall
// independently; the queue absorbs a stalled output register so requests
// keep flowing until it fills. Table writes produce no result and do not
// advance the pixel position. The table is not cleared at reset: load
// every entry a pixel will use first. Indices at or above PALETTE_ENTRIES
// read as pen 0 and writes to them are dropped. dither_mode may only be
// changed while the block is idle; codes 5 to 7 act as Bayer 4x4.
module ordered_dither_chunky_to_planar_unit import odc2p_pkg::*; #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        dither_mode_we,
	input  logic [2:0]  dither_mode,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  pixel_index,
	input  logic [3:0]  near_pen,
	input  logic [3:0]  far_pen,
	input  logic [4:0]  mix_level,
	input  logic [1:0]  row_phase,
	input  logic [3:0]  noise_level,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] plane_word_0,
	output logic [15:0] plane_word_1,
	output logic [15:0] plane_word_2,
	output logic [15:0] plane_word_3
);

	logic [MODE_W-1:0] mode_q;
	logic              f_valid;
	logic              f_ready;
	pix_req_t          f_req;
	logic              b_valid;
	logic              b_ready;
	pix_req_t          b_req;

	// Mode register, Bayer 4x4 out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BAYER4;
		end else if (dither_mode_we) begin
			mode_q <= dither_mode;
		end
	end

	// Lookup stage: writes land in the table, pixels fetch their entry
	odc2p_front #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.pixel_index(pixel_index),
		.near_pen   (near_pen),
		.far_pen    (far_pen),
		.mix_level  (mix_level),
		.row_phase  (row_phase),
		.noise_level(noise_level),
		.req_valid  (f_valid),
		.req_ready  (f_ready),
		.req        (f_req)
	);

	// Decoupling queue
	odc2p_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_req),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_req)
	);

	// Pen choice, plane packing and output register
	odc2p_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode_q),
		.req_valid   (b_valid),
		.req_ready   (b_ready),
		.req         (b_req),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.plane_word_0(plane_word_0),
		.plane_word_1(plane_word_1),
		.plane_word_2(plane_word_2),
		.plane_word_3(plane_word_3)
	);

endmodule

/* tb/tb_ordered_dither_chunky_to_planar_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the ordered-dither chunky-to-planar unit.
module tb_ordered_dither_chunky_to_planar_unit;
	import odc2p_pkg::*;

	// Dither threshold tables, indexed by {row phase, column}
	localparam logic [3:0] ORDER4_THR [16] = '{
		4'd0, 4'd8, 4'd2, 4'd10, 4'd12, 4'd4, 4'd14, 4'd6,
		4'd3, 4'd11, 4'd1, 4'd9, 4'd15, 4'd7, 4'd13, 4'd5
	};
	localparam logic [3:0] ORDER2_THR [4] = '{4'd2, 4'd10, 4'd14, 4'd6};
	localparam logic [3:0] HALFTONE_THR [16] = '{
		4'd6, 4'd7, 4'd8, 4'd9, 4'd5, 4'd0, 4'd1, 4'd10,
		4'd4, 4'd3, 4'd2, 4'd11, 4'd15, 4'd14, 4'd13, 4'd12
	};

	// Spare mode codes; the block treats them as Bayer 4x4
	localparam logic [2:0] MODE_SPARE_5 = 3'd5;
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;

	// Mode used by each random phase; covers every code, both extremes included
	localparam int         PHASES = 12;
	localparam logic [2:0] PHASE_MODES [PHASES] = '{
		MODE_NEAREST, MODE_BAYER2, MODE_BAYER4, MODE_HALFTONE,
		MODE_NOISE, MODE_SPARE_7, MODE_SPARE_5, MODE_SPARE_6,
		MODE_NOISE, MODE_BAYER2, MODE_HALFTONE, MODE_NEAREST
	};
	localparam int ITEMS_PER_PHASE = 102;

	// Cycles allowed after the last block for in-flight requests to drain
	localparam int DRAIN_CYCLES = 8;

	// Predicts the plane words from accepted requests and checks the results.
	// Pens are resolved at acceptance with the mode in force at that time.
	class planar_predictor;
		logic [2:0]       mode;
		entry_t           pair_lut [256];
		logic [3:0][15:0] planes;
		logic [3:0]       column_pos;
		logic [3:0][15:0] blocks_due [$];
		int               fails;

		function new();
			mode       = MODE_BAYER4;
			planes     = '0;
			column_pos = '0;
			fails      = 0;
		endfunction

		function void note_request(op_t kind, logic [7:0] addr, pen_t np, pen_t fp,
			logic [4:0] mix, logic [1:0] row, logic [3:0] noise);
			entry_t     e;
			logic [3:0] cell_sel;
			logic [3:0] thr;
			pen_t       pen;
			if (kind == OP_WRITE) begin
				pair_lut[addr].near_pen = np;
				pair_lut[addr].far_pen  = fp;
				pair_lut[addr].mix      = mix;
				return;
			end
			e        = pair_lut[addr];
			cell_sel = {row, column_pos[1:0]};
			if (mode == MODE_NOISE)
				thr = noise;
			else if (mode == MODE_BAYER2)
				thr = ORDER2_THR[{cell_sel[2], cell_sel[0]}];
			else if (mode == MODE_HALFTONE)
				thr = HALFTONE_THR[cell_sel];
			else
				thr = ORDER4_THR[cell_sel];
			// mix is 5 bits, so values of 16 and above beat every threshold
			if (mode != MODE_NEAREST && int'(e.mix) > int'(thr))
				pen = e.far_pen;
			else
				pen = e.near_pen;
			for (int k = 0; k < 4; k++)
				planes[k][15 - int'(column_pos)] = pen[k];
			if (column_pos == 4'd15) begin
				blocks_due.push_back(planes);
				planes = '0;
			end
			column_pos = column_pos + 4'd1;
		endfunction

		function void check_block(logic [3:0][15:0] got);
			logic [3:0][15:0] want;
			if (blocks_due.size() == 0) begin
				$display("%0t: unexpected block, got %h %h %h %h", $time,
					got[0], got[1], got[2], got[3]);
				fails++;
				return;
			end
			want = blocks_due.pop_front();
			for (int k = 0; k < 4; k++) begin
				if (want[k] !== got[k]) begin
					$display("%0t: plane_word_%0d expected %h actual %h", $time, k,
						want[k], got[k]);
					fails++;
				end
			end
		endfunction

		function int pending();
			return blocks_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        dither_mode_we;
	logic [2:0]  dither_mode;
	logic        in_valid;
	logic        in_ready;
	logic        op;
	logic [7:0]  pixel_index;
	logic [3:0]  near_pen;
	logic [3:0]  far_pen;
	logic [4:0]  mix_level;
	logic [1:0]  row_phase;
	logic [3:0]  noise_level;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] plane_word_0;
	logic [15:0] plane_word_1;
	logic [15:0] plane_word_2;
	logic [15:0] plane_word_3;

	planar_predictor pred = new();
	bit              written [256];  // entries that pixels may read
	int              items_sent;

	ordered_dither_chunky_to_planar_unit #(
		.PALETTE_ENTRIES(256)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.dither_mode_we(dither_mode_we),
		.dither_mode   (dither_mode),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.pixel_index   (pixel_index),
		.near_pen      (near_pen),
		.far_pen       (far_pen),
		.mix_level     (mix_level),
		.row_phase     (row_phase),
		.noise_level   (noise_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.plane_word_0  (plane_word_0),
		.plane_word_1  (plane_word_1),
		.plane_word_2  (plane_word_2),
		.plane_word_3  (plane_word_3)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("ordered_dither_chunky_to_planar_unit test failed");
		$finish;
	end

	// Offers one request, starting and ending at a falling edge. Random gaps
	// go in front of it, except in a calm stretch mid-run. Valid stays high
	// with a stable payload until the handshake.
	task automatic send_item(input op_t kind, input logic [7:0] addr, input pen_t np,
		input pen_t fp, input logic [4:0] mix, input logic [1:0] row,
		input logic [3:0] noise);
		bit calm;
		calm = (items_sent >= 600 && items_sent < 800);
		while (!calm && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		op          <= kind;
		pixel_index <= addr;
		near_pen    <= np;
		far_pen     <= fp;
		mix_level   <= mix;
		row_phase   <= row;
		noise_level <= noise;
		do @(posedge clk); while (!in_ready);
		pred.note_request(kind, addr, np, fp, mix, row, noise);
		if (kind == OP_WRITE)
			written[addr] = 1'b1;
		items_sent++;
		@(negedge clk);
	endtask

	// Drops valid, waits for every predicted block, then lets writes
	// (which give no result) and a partial block settle inside the pipe.
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pred.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Result side: random stalls, one long hold-off to back the block up
	// into its input, and a calm stretch with no stalls at all.
	initial begin : result_sink
		int hold_left;
		int seen;
		bit held;
		hold_left = 0;
		seen      = 0;
		held      = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				pred.check_block({plane_word_3, plane_word_2, plane_word_1, plane_word_0});
				seen++;
			end
			@(negedge clk);
			if (!held && seen == 8) begin
				held      = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (seen >= 20 && seen < 36) || ($urandom_range(99) >= 21);
			end
		end
	end

	initial begin : stimulus
		logic [7:0] addr;
		items_sent     = 0;
		arst_n         = 1'b0;
		dither_mode_we = 1'b0;
		dither_mode    = MODE_BAYER4;
		in_valid       = 1'b0;
		op             = OP_WRITE;
		pixel_index    = '0;
		near_pen       = '0;
		far_pen        = '0;
		mix_level      = '0;
		row_phase      = '0;
		noise_level    = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: load extreme entries, including mix levels above 16,
		// then one full block in the reset mode (Bayer 4x4) with a table
		// write dropped into the middle of it, which must not shift the column.
		send_item(OP_WRITE, 8'h00, 4'd0,  4'd15, 5'd16, 2'd0, 4'd0);
		send_item(OP_WRITE, 8'hff, 4'd15, 4'd0,  5'd31, 2'd3, 4'd15);
		send_item(OP_WRITE, 8'h55, 4'd5,  4'd10, 5'd0,  2'd1, 4'd5);
		send_item(OP_WRITE, 8'haa, 4'd10, 4'd5,  5'd17, 2'd2, 4'd10);
		send_item(OP_WRITE, 8'h01, 4'd3,  4'd12, 5'd8,  2'd0, 4'd0);
		for (int n = 0; n < 16; n++) begin
			case (n % 4)
				0: addr = 8'h00;
				1: addr = 8'hff;
				2: addr = 8'h01;
				default: addr = (n < 8) ? 8'h55 : 8'haa;
			endcase
			send_item(OP_PIXEL, addr, 4'd15, 4'd15, 5'd31, 2'(n / 4), 4'(n * 5));
			if (n == 7)
				send_item(OP_WRITE, 8'h80, 4'd9, 4'd6, 5'd1, 2'd3, 4'd15);
		end

		// Random phases, one mode each; the mode changes only while idle
		for (int p = 0; p < PHASES; p++) begin
			settle_idle();
			dither_mode_we <= 1'b1;
			dither_mode    <= PHASE_MODES[p];
			pred.mode = PHASE_MODES[p];
			@(negedge clk);
			dither_mode_we <= 1'b0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(99) < 15) begin
					// Table write; mostly in range mix levels, some above 16
					addr = 8'($urandom_range(255));
					send_item(OP_WRITE, addr, 4'($urandom_range(15)), 4'($urandom_range(15)),
						($urandom_range(9) == 0) ? 5'($urandom_range(31, 17))
							: 5'($urandom_range(16)),
						2'($urandom_range(3)), 4'($urandom_range(15)));
				end else begin
					// Pixel reads only entries loaded before
					do addr = 8'($urandom_range(255)); while (!written[addr]);
					send_item(OP_PIXEL, addr, 4'($urandom_range(15)), 4'($urandom_range(15)),
						5'($urandom_range(31)), 2'($urandom_range(3)),
						4'($urandom_range(15)));
				end
			end
		end

		settle_idle();
		if (pred.fails == 0 && pred.pending() == 0)
			$display("ordered_dither_chunky_to_planar_unit test passed");
		else
			$display("ordered_dither_chunky_to_planar_unit test failed");
		$finish;
	end

endmodule
